// ===== design/nfid_pkg.sv =====
`default_nettype none

package nfid_pkg;

    localparam int ID_W     = 8;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = HANDLE_W + 1;
    localparam int VALID_B  = HANDLE_W;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_BIND    = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ID_W-1:0]     id_in;
        logic [HANDLE_W-1:0] owner_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     id_out;
        logic                found;
        logic [HANDLE_W-1:0] handle_out;
    } rsp_t;

endpackage

`default_nettype wire

// ===== design/nfid_ram.sv =====
`default_nettype none

module nfid_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/nfid_wrap.sv =====
`default_nettype none

// pointer step: one past cur, back to MIN_ID when outside MIN_ID..MAX_ID
module nfid_wrap #(
    parameter int MAX_ID = 255,
    parameter int MIN_ID = 2,
    parameter int AW     = 8
) (
    input  wire logic [AW-1:0] cur,
    output logic      [AW-1:0] nxt
);

    logic [AW:0] sum;

    always_comb
    begin
        sum = {1'b0, cur} + (AW+1)'(1);
        if (sum > (AW+1)'(MAX_ID) || sum < (AW+1)'(MIN_ID))
        begin
            nxt = AW'(MIN_ID);
        end
        else
        begin
            nxt = sum[AW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/nfid_seq.sv =====
`default_nettype none

module nfid_seq #(
    parameter int MAX_ID    = 255,
    parameter int MIN_ID    = 2,
    parameter int KERNEL_ID = 1,
    parameter int AW        = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire nfid_pkg::req_t            req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output nfid_pkg::rsp_t                 rsp,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [nfid_pkg::SLOT_W-1:0]    ram_wdata,
    output logic [AW-1:0]                  ram_raddr,
    input  wire logic [nfid_pkg::SLOT_W-1:0] ram_rdata
);

    import nfid_pkg::*;

    localparam int NPROBE    = MAX_ID - MIN_ID + 1;
    localparam bit KERNEL_OK = (KERNEL_ID <= MAX_ID);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_LOOK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       p_reg, p_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [AW-1:0]       p_wrap;
    logic                id_big;

    nfid_wrap #(
        .MAX_ID (MAX_ID),
        .MIN_ID (MIN_ID),
        .AW     (AW)
    ) u_wrap (
        .cur (p_reg),
        .nxt (p_wrap)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign id_big    = (32'(req.id_in) > 32'(MAX_ID));

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        handle_next    = handle_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = p_reg;
        ram_wdata      = '0;
        ram_raddr      = p_wrap;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == AW'(MAX_ID))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                ram_raddr = (req.opcode == OP_ALLOC) ? ptr_reg : AW'(req.id_in);
                if (req_valid)
                begin
                    handle_next         = req.owner_handle;
                    res_next.status     = STAT_OK;
                    res_next.id_out     = req.id_in;
                    res_next.found      = 1'b0;
                    res_next.handle_out = '0;
                    state_next          = S_DONE;
                    case (req.opcode)
                        OP_ALLOC:
                        begin
                            p_next     = ptr_reg;
                            cnt_next   = '0;
                            state_next = S_PROBE;
                        end
                        OP_BIND:
                        begin
                            if (KERNEL_OK)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = AW'(KERNEL_ID);
                                ram_wdata       = {1'b1, req.owner_handle};
                                res_next.id_out = ID_W'(KERNEL_ID);
                            end
                            else
                            begin
                                res_next.status = STAT_RANGE;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (id_big)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(req.id_in);
                            end
                        end
                        default:
                        begin
                            if (id_big)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (!ram_rdata[VALID_B])
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = p_reg;
                    ram_wdata       = {1'b1, handle_reg};
                    res_next.id_out = ID_W'(p_reg);
                    ptr_next        = p_wrap;
                    state_next      = S_DONE;
                end
                else if (cnt_reg == AW'(NPROBE - 1))
                begin
                    res_next.status = STAT_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    p_next   = p_wrap;
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_LOOK:
            begin
                res_next.found      = ram_rdata[VALID_B];
                res_next.handle_out = ram_rdata[VALID_B] ? ram_rdata[HANDLE_W-1:0] : '0;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= AW'(MIN_ID);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        handle_reg <= handle_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== design/next_fit_id_allocator.sv =====
`default_nettype none

// channel  | valid     | ready     | payload
// request  | req_valid | req_ready | req (opcode, id_in, owner_handle)
// response | rsp_valid | rsp_ready | rsp (status, id_out, found, handle_out)
//
// Allocate: probes slots from the next-fit pointer, up to MAX_ID-MIN_ID+1 probes;
// one read of the slot RAM per cycle sets the scan rate.
// Release and bind: IDLE then DONE. Lookup: IDLE, LOOK, DONE (registered RAM read).
// After reset a clearing pass writes every slot, with req_ready low.
// A new request is taken while a response waits; a second result waits for rsp_ready.
module next_fit_id_allocator #(
    parameter int MAX_ID    = 255,
    parameter int MIN_ID    = 2,
    parameter int KERNEL_ID = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire nfid_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output nfid_pkg::rsp_t      rsp
);

    import nfid_pkg::*;

    localparam int DEPTH = MAX_ID + 1;
    localparam int AW    = $clog2(DEPTH);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    nfid_seq #(
        .MAX_ID    (MAX_ID),
        .MIN_ID    (MIN_ID),
        .KERNEL_ID (KERNEL_ID),
        .AW        (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    nfid_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
